@@ design/vgsc_pkg.sv @@
// shared types and constants for the voxel grid edit and sphere carve block
`timescale 1ns / 1ps

package vgsc_pkg;

    // operation codes carried in the mode field
    localparam logic [1:0] MODE_SET   = 2'd0;
    localparam logic [1:0] MODE_RDC   = 2'd1;
    localparam logic [1:0] MODE_RDS   = 2'd2;
    localparam logic [1:0] MODE_CARVE = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_SIZE_X  = 2'd0;
    localparam logic [1:0] REG_SIZE_Y  = 2'd1;
    localparam logic [1:0] REG_SIZE_Z  = 2'd2;
    localparam logic [1:0] REG_DEFAULT = 2'd3;

    localparam int COORD_W  = 8;
    localparam int CENTER_W = 16;
    localparam int RADIUS_W = 14;

    // density codes
    localparam logic [1:0] DENS_NONE  = 2'b00;
    localparam logic [1:0] DENS_AIR   = 2'b01;
    localparam logic [1:0] DENS_SOLID = 2'b11;

    // classified command handed from the front end to the back end
    typedef struct packed {
        logic [1:0]            mode;
        logic                  in_cell;
        logic                  in_corner;
        logic [7:0]            x;
        logic [7:0]            y;
        logic [7:0]            z;
        logic [7:0]            new_type;
        logic [CENTER_W-1:0]   cx;
        logic [CENTER_W-1:0]   cy;
        logic [CENTER_W-1:0]   cz;
        logic [22:0]           r;
    } t_cmd;

endpackage

@@ design/voxel_grid_edit_and_sphere_carve_top.sv @@
// top level: configuration registers, front end, one-entry queue and back end
`timescale 1ns / 1ps

// Voxel grid edit and sphere carve. After reset, and after a size register
// write that finds the back end idle, both grids are swept to the default
// type one corner entry a cycle over all (MAX_DIM+1)^3 entries (4913 at the
// defaults), while the back end takes no command. A set writes the cell and
// its eight corners through one write port; a carve makes a single fetch and
// check-and-write pass of the walk over both grids, cells first, then corners.
// Configuration writes are taken in any cycle and belong in idle periods.
module voxel_grid_edit_and_sphere_carve_top #(
    parameter int MAX_DIM    = 16,
    parameter int TYPE_BITS  = 4,
    parameter int MAX_RADIUS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_mode,
    input  logic signed [7:0]  i_coord_x,
    input  logic signed [7:0]  i_coord_y,
    input  logic signed [7:0]  i_coord_z,
    input  logic [3:0]         i_new_type,
    input  logic signed [15:0] i_center_x,
    input  logic signed [15:0] i_center_y,
    input  logic signed [15:0] i_center_z,
    input  logic [13:0]        i_radius,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [4:0]         i_cfg_data,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [3:0]         o_block_type,
    output logic signed [1:0]  o_density,
    output logic               o_ok,
    output logic               o_changed
);

    logic [7:0]           r_size_x, r_size_y, r_size_z;
    logic [TYPE_BITS-1:0] r_default;
    logic                 r_refill;
    logic [7:0]           w_clamp;
    logic                 w_cmd_valid, w_cmd_ready;
    vgsc_pkg::t_cmd       w_cmd;

    assign o_cfg_ready = 1'b1;

    // size clamp into one to MAX_DIM
    always_comb begin
        if (i_cfg_data == 5'd0) w_clamp = 8'd1;
        else if (32'(i_cfg_data) > MAX_DIM) w_clamp = 8'(MAX_DIM);
        else w_clamp = 8'(i_cfg_data);
    end

    // configuration registers; a size write asks for a refill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x  <= 8'(MAX_DIM < 16 ? MAX_DIM : 16);
            r_size_y  <= 8'(MAX_DIM < 16 ? MAX_DIM : 16);
            r_size_z  <= 8'(MAX_DIM < 16 ? MAX_DIM : 16);
            r_default <= TYPE_BITS'(1);
            r_refill  <= 1'b0;
        end else begin
            r_refill <= 1'b0;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    vgsc_pkg::REG_SIZE_X: begin r_size_x <= w_clamp; r_refill <= 1'b1; end
                    vgsc_pkg::REG_SIZE_Y: begin r_size_y <= w_clamp; r_refill <= 1'b1; end
                    vgsc_pkg::REG_SIZE_Z: begin r_size_z <= w_clamp; r_refill <= 1'b1; end
                    vgsc_pkg::REG_DEFAULT:
                        r_default <= TYPE_BITS'(i_cfg_data[3:0]);
                    default: ;
                endcase
            end
        end
    end

    vgsc_front #(.TYPE_BITS(TYPE_BITS), .MAX_RADIUS(MAX_RADIUS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_mode(i_mode), .i_coord_x(i_coord_x), .i_coord_y(i_coord_y),
        .i_coord_z(i_coord_z), .i_new_type(i_new_type), .i_center_x(i_center_x),
        .i_center_y(i_center_y), .i_center_z(i_center_z), .i_radius(i_radius),
        .i_size_x(r_size_x), .i_size_y(r_size_y), .i_size_z(r_size_z),
        .o_cmd_valid(w_cmd_valid), .i_cmd_ready(w_cmd_ready), .o_cmd(w_cmd)
    );

    vgsc_back #(.MAX_DIM(MAX_DIM), .TYPE_BITS(TYPE_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd_valid(w_cmd_valid),
        .o_cmd_ready(w_cmd_ready), .i_cmd(w_cmd), .i_size_x(r_size_x),
        .i_size_y(r_size_y), .i_size_z(r_size_z), .i_default(r_default),
        .i_refill(r_refill), .o_valid(o_valid), .i_ready(i_ready),
        .o_block_type(o_block_type), .o_density(o_density), .o_ok(o_ok),
        .o_changed(o_changed)
    );

endmodule

@@ design/vgsc_front.sv @@
// front end: input beat capture, bounds classification and radius saturation
`timescale 1ns / 1ps

module vgsc_front #(
    parameter int TYPE_BITS  = 4,
    parameter int MAX_RADIUS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [1:0]                          i_mode,
    input  logic signed [vgsc_pkg::COORD_W-1:0] i_coord_x,
    input  logic signed [vgsc_pkg::COORD_W-1:0] i_coord_y,
    input  logic signed [vgsc_pkg::COORD_W-1:0] i_coord_z,
    input  logic [3:0]                          i_new_type,
    input  logic signed [vgsc_pkg::CENTER_W-1:0] i_center_x,
    input  logic signed [vgsc_pkg::CENTER_W-1:0] i_center_y,
    input  logic signed [vgsc_pkg::CENTER_W-1:0] i_center_z,
    input  logic [vgsc_pkg::RADIUS_W-1:0]       i_radius,
    input  logic [7:0]                          i_size_x,
    input  logic [7:0]                          i_size_y,
    input  logic [7:0]                          i_size_z,
    output logic                                o_cmd_valid,
    input  logic                                i_cmd_ready,
    output vgsc_pkg::t_cmd                      o_cmd
);

    localparam logic [22:0] RMAX = 23'(MAX_RADIUS * 256);

    vgsc_pkg::t_cmd r_cmd, n_cmd;
    logic           r_vld;
    logic           w_cx, w_cy, w_cz, w_kx, w_ky, w_kz;

    assign o_ready     = !r_vld || i_cmd_ready;
    assign o_cmd_valid = r_vld;
    assign o_cmd       = r_cmd;

    // bounds tests; negative coordinates fail through the sign bit
    always_comb begin
        w_cx = !i_coord_x[7] && ({1'b0, i_coord_x} < {1'b0, i_size_x});
        w_cy = !i_coord_y[7] && ({1'b0, i_coord_y} < {1'b0, i_size_y});
        w_cz = !i_coord_z[7] && ({1'b0, i_coord_z} < {1'b0, i_size_z});
        w_kx = !i_coord_x[7] && ({1'b0, i_coord_x} <= {1'b0, i_size_x});
        w_ky = !i_coord_y[7] && ({1'b0, i_coord_y} <= {1'b0, i_size_y});
        w_kz = !i_coord_z[7] && ({1'b0, i_coord_z} <= {1'b0, i_size_z});
        n_cmd.mode      = i_mode;
        n_cmd.in_cell   = w_cx && w_cy && w_cz;
        n_cmd.in_corner = w_kx && w_ky && w_kz;
        n_cmd.x         = i_coord_x;
        n_cmd.y         = i_coord_y;
        n_cmd.z         = i_coord_z;
        n_cmd.new_type  = 8'(i_new_type & 4'((1 << TYPE_BITS) - 1));
        n_cmd.cx        = i_center_x;
        n_cmd.cy        = i_center_y;
        n_cmd.cz        = i_center_z;
        n_cmd.r         = (23'(i_radius) > RMAX) ? RMAX : 23'(i_radius);
    end

    // one-entry queue toward the back end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

@@ design/vgsc_back.sv @@
// back end: grid memories, clearing sweep, set, reads and sphere carve walk
`timescale 1ns / 1ps

module vgsc_back #(
    parameter int MAX_DIM   = 16,
    parameter int TYPE_BITS = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cmd_valid,
    output logic                 o_cmd_ready,
    input  vgsc_pkg::t_cmd       i_cmd,
    input  logic [7:0]           i_size_x,
    input  logic [7:0]           i_size_y,
    input  logic [7:0]           i_size_z,
    input  logic [TYPE_BITS-1:0] i_default,
    input  logic                 i_refill,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [3:0]           o_block_type,
    output logic signed [1:0]    o_density,
    output logic                 o_ok,
    output logic                 o_changed
);

    localparam int CD     = MAX_DIM + 1;
    localparam int DW     = $clog2(CD + 1);
    localparam int CDEPTH = MAX_DIM * MAX_DIM * MAX_DIM;
    localparam int KDEPTH = CD * CD * CD;
    localparam int CAW    = $clog2(CDEPTH);
    localparam int KAW    = $clog2(KDEPTH);
    localparam logic [TYPE_BITS-1:0] AIR = '0;

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_SET   = 8'b0000_0100,
        ST_RD    = 8'b0000_1000,
        ST_RDW   = 8'b0001_0000,
        ST_CARVE = 8'b0010_0000,
        ST_CHK   = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } t_state;

    t_state r_state;
    logic [TYPE_BITS-1:0] cell_mem [CDEPTH];
    logic [TYPE_BITS-1:0] corn_mem [KDEPTH];
    logic [TYPE_BITS-1:0] r_crd, r_krd;

    vgsc_pkg::t_cmd r_cmd;
    logic [DW-1:0]  r_i, r_j, r_k;
    logic           r_grid;    // 0 walks cells, 1 walks corners
    logic [2:0]     r_n;
    logic [KAW-1:0] r_clr;
    logic           r_changed;
    logic [DW-1:0]  r_pi, r_pj, r_pk;
    logic           r_pgrid;
    logic           r_pend;
    logic           r_ovld;
    logic [3:0]     r_otype;
    logic [1:0]     r_odens;
    logic           r_ook, r_ochg;

    // sphere distance datapath: the three axis products are registered, then summed
    logic signed [19:0] w_dx, w_dy, w_dz;
    logic [39:0]        r_sx, r_sy, r_sz;
    logic [45:0]        r_rr;
    logic [41:0]        w_sum;
    logic               w_in;

    function automatic logic signed [19:0] pos(input logic [DW-1:0] v, input logic g);
        return g ? 20'sd0 + $signed({1'b0, v, 8'h00})
                 : 20'sd0 + $signed({1'b0, v, 8'h80});
    endfunction

    assign w_dx  = pos(r_i, r_grid) - 20'(signed'(r_cmd.cx));
    assign w_dy  = pos(r_j, r_grid) - 20'(signed'(r_cmd.cy));
    assign w_dz  = pos(r_k, r_grid) - 20'(signed'(r_cmd.cz));
    assign w_sum = 42'(r_sx) + 42'(r_sy) + 42'(r_sz);
    assign w_in  = 46'(w_sum) <= r_rr;

    logic [DW-1:0] w_lx, w_ly, w_lz;
    assign w_lx = r_grid ? DW'(i_size_x) : DW'(i_size_x - 8'd1);
    assign w_ly = r_grid ? DW'(i_size_y) : DW'(i_size_y - 8'd1);
    assign w_lz = r_grid ? DW'(i_size_z) : DW'(i_size_z - 8'd1);

    function automatic logic [CAW-1:0] caddr(input logic [DW-1:0] x, input logic [DW-1:0] y,
                                             input logic [DW-1:0] z);
        return CAW'(x + MAX_DIM * (y + MAX_DIM * 32'(z)));
    endfunction
    function automatic logic [KAW-1:0] kaddr(input logic [DW-1:0] x, input logic [DW-1:0] y,
                                             input logic [DW-1:0] z);
        return KAW'(x + CD * (y + CD * 32'(z)));
    endfunction

    logic [DW-1:0] w_sx, w_sy, w_sz;
    assign w_sx = DW'(r_cmd.x) + DW'(r_n[0]);
    assign w_sy = DW'(r_cmd.y) + DW'(r_n[1]);
    assign w_sz = DW'(r_cmd.z) + DW'(r_n[2]);

    assign o_cmd_ready  = (r_state == ST_IDLE) && !r_ovld && !i_refill;
    assign o_valid      = r_ovld;
    assign o_block_type = r_otype;
    assign o_density    = r_odens;
    assign o_ok         = r_ook;
    assign o_changed    = r_ochg;

    // memory ports: one write and one registered read each
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_CLEAR: begin
                if (r_clr < KAW'(CDEPTH)) cell_mem[CAW'(r_clr)] <= i_default;
                corn_mem[r_clr] <= i_default;
            end
            ST_SET: begin
                if (r_n == 3'd0) cell_mem[caddr(DW'(r_cmd.x), DW'(r_cmd.y), DW'(r_cmd.z))]
                    <= TYPE_BITS'(r_cmd.new_type);
                corn_mem[kaddr(w_sx, w_sy, w_sz)] <= TYPE_BITS'(r_cmd.new_type);
            end
            ST_CHK: begin
                if (r_pend && w_in && !r_pgrid && r_crd != AIR)
                    cell_mem[caddr(r_pi, r_pj, r_pk)] <= AIR;
                if (r_pend && w_in && r_pgrid && r_krd != AIR)
                    corn_mem[kaddr(r_pi, r_pj, r_pk)] <= AIR;
            end
            default: ;
        endcase
        if (r_state == ST_CARVE) begin
            r_crd <= cell_mem[caddr(r_i, r_j, r_k)];
            r_krd <= corn_mem[kaddr(r_i, r_j, r_k)];
        end else begin
            r_crd <= cell_mem[caddr(DW'(r_cmd.x), DW'(r_cmd.y), DW'(r_cmd.z))];
            r_krd <= corn_mem[kaddr(DW'(r_cmd.x), DW'(r_cmd.y), DW'(r_cmd.z))];
        end
    end

    // sequencer; a carve alternates a fetch state and a check-and-write state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_ovld  <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            if (r_ovld && i_ready) r_ovld <= 1'b0;
            case (r_state)
                ST_CLEAR: begin
                    if (r_clr == KAW'(KDEPTH - 1)) r_state <= ST_IDLE;
                    else r_clr <= r_clr + 1'b1;
                end
                ST_IDLE: begin
                    if (i_refill) begin
                        r_clr   <= '0;
                        r_state <= ST_CLEAR;
                    end else if (i_cmd_valid && !r_ovld) begin
                        r_cmd     <= i_cmd;
                        r_n       <= '0;
                        r_i       <= '0;
                        r_j       <= '0;
                        r_k       <= '0;
                        r_grid    <= 1'b0;
                        r_changed <= 1'b0;
                        r_pend    <= 1'b0;
                        r_rr      <= 46'(i_cmd.r) * 46'(i_cmd.r);
                        case (i_cmd.mode)
                            vgsc_pkg::MODE_SET:
                                r_state <= i_cmd.in_cell ? ST_SET : ST_OUT;
                            vgsc_pkg::MODE_CARVE: r_state <= ST_CARVE;
                            default: r_state <= ST_RD;
                        endcase
                    end
                end
                ST_SET: begin
                    r_n <= r_n + 3'd1;
                    if (r_n == 3'd7) r_state <= ST_OUT;
                end
                ST_RD:  r_state <= ST_RDW;
                ST_RDW: r_state <= ST_OUT;
                ST_CARVE: begin
                    r_sx    <= 40'(w_dx * w_dx);
                    r_sy    <= 40'(w_dy * w_dy);
                    r_sz    <= 40'(w_dz * w_dz);
                    r_pi    <= r_i;
                    r_pj    <= r_j;
                    r_pk    <= r_k;
                    r_pgrid <= r_grid;
                    r_pend  <= 1'b1;
                    r_state <= ST_CHK;
                end
                ST_CHK: begin
                    if (r_pend && w_in &&
                        ((!r_pgrid && r_crd != AIR) || (r_pgrid && r_krd != AIR)))
                        r_changed <= 1'b1;
                    r_pend <= 1'b0;
                    // step to the next point, cells first then corners
                    if (r_i != w_lx) begin
                        r_i <= r_i + 1'b1;
                        r_state <= ST_CARVE;
                    end else if (r_j != w_ly) begin
                        r_i <= '0; r_j <= r_j + 1'b1;
                        r_state <= ST_CARVE;
                    end else if (r_k != w_lz) begin
                        r_i <= '0; r_j <= '0; r_k <= r_k + 1'b1;
                        r_state <= ST_CARVE;
                    end else if (!r_grid) begin
                        r_i <= '0; r_j <= '0; r_k <= '0; r_grid <= 1'b1;
                        r_state <= ST_CARVE;
                    end else begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    r_ovld  <= 1'b1;
                    r_otype <= '0;
                    r_odens <= vgsc_pkg::DENS_NONE;
                    r_ook   <= 1'b0;
                    r_ochg  <= 1'b0;
                    case (r_cmd.mode)
                        vgsc_pkg::MODE_SET: r_ook <= r_cmd.in_cell;
                        vgsc_pkg::MODE_RDC: begin
                            r_ook   <= r_cmd.in_cell;
                            r_otype <= r_cmd.in_cell ? 4'(r_crd) : 4'd0;
                        end
                        vgsc_pkg::MODE_RDS: begin
                            r_ook   <= r_cmd.in_corner;
                            r_otype <= r_cmd.in_corner ? 4'(r_krd) : 4'd0;
                            r_odens <= (r_cmd.in_corner && r_krd != AIR) ?
                                       vgsc_pkg::DENS_SOLID : vgsc_pkg::DENS_AIR;
                        end
                        default: r_ochg <= r_changed;
                    endcase
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

@@ bench/vgsc_checker.sv @@
// scoreboard for the voxel grid block: grid shadow, result prediction and compare
`timescale 1ns / 1ps

module vgsc_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_in_ready,
    input  logic [1:0]         i_mode,
    input  logic signed [7:0]  i_coord_x,
    input  logic signed [7:0]  i_coord_y,
    input  logic signed [7:0]  i_coord_z,
    input  logic [3:0]         i_new_type,
    input  logic signed [15:0] i_center_x,
    input  logic signed [15:0] i_center_y,
    input  logic signed [15:0] i_center_z,
    input  logic [13:0]        i_radius,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [4:0]         i_cfg_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [3:0]         i_block_type,
    input  logic signed [1:0]  i_density,
    input  logic               i_ok,
    input  logic               i_changed,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam int DIM     = 16;
    localparam int CDIM    = DIM + 1;
    localparam int R_LIMIT = 64 * 256;

    typedef struct packed {
        logic [3:0] btype;
        logic [1:0] dens;
        logic       ok;
        logic       changed;
    } t_vox_result;

    logic [3:0]  cell_grid [DIM*DIM*DIM];
    logic [3:0]  corner_grid [CDIM*CDIM*CDIM];
    int          dim_x, dim_y, dim_z;
    logic [3:0]  fill_type;
    t_vox_result expected_results[$];
    int          beat_no;

    function automatic int clamp_dim(logic [4:0] v);
        if (v == 0) return 1;
        if (v > DIM) return DIM;
        return int'(v);
    endfunction

    function automatic void refill_grids();
        foreach (cell_grid[n]) cell_grid[n] = fill_type;
        foreach (corner_grid[n]) corner_grid[n] = fill_type;
    endfunction

    function automatic bit in_sphere(longint px, longint py, longint pz,
                                     longint cx, longint cy, longint cz, longint r);
        longint dx, dy, dz;
        dx = px - cx;
        dy = py - cy;
        dz = pz - cz;
        return (dx * dx + dy * dy + dz * dz) <= r * r;
    endfunction

    // apply one command to the shadow grids and return its result
    function automatic t_vox_result apply_command(logic [1:0] md, int x, int y, int z,
                                                  logic [3:0] nt, longint cx, longint cy,
                                                  longint cz, longint r);
        t_vox_result res;
        bit          cell_in, corner_in;
        int          n;
        res = '0;
        cell_in = x >= 0 && x < dim_x && y >= 0 && y < dim_y && z >= 0 && z < dim_z;
        corner_in = x >= 0 && x <= dim_x && y >= 0 && y <= dim_y && z >= 0 && z <= dim_z;
        case (md)
            vgsc_pkg::MODE_SET: begin
                if (cell_in) begin
                    cell_grid[x + DIM * (y + DIM * z)] = nt;
                    for (int c = 0; c <= 1; c++)
                        for (int b = 0; b <= 1; b++)
                            for (int a = 0; a <= 1; a++)
                                corner_grid[(x + a) + CDIM * ((y + b) + CDIM * (z + c))] = nt;
                    res.ok = 1'b1;
                end
            end
            vgsc_pkg::MODE_RDC: begin
                if (cell_in) begin
                    res.btype = cell_grid[x + DIM * (y + DIM * z)];
                    res.ok = 1'b1;
                end
            end
            vgsc_pkg::MODE_RDS: begin
                if (corner_in) begin
                    res.btype = corner_grid[x + CDIM * (y + CDIM * z)];
                    res.ok = 1'b1;
                end
                res.dens = (res.btype == 0) ? vgsc_pkg::DENS_AIR : vgsc_pkg::DENS_SOLID;
            end
            default: begin
                if (r > R_LIMIT) r = R_LIMIT;
                for (int k = 0; k < dim_z; k++)
                    for (int j = 0; j < dim_y; j++)
                        for (int i = 0; i < dim_x; i++) begin
                            n = i + DIM * (j + DIM * k);
                            if (cell_grid[n] != 0 && in_sphere(i * 256 + 128, j * 256 + 128,
                                    k * 256 + 128, cx, cy, cz, r)) begin
                                cell_grid[n] = 0;
                                res.changed = 1'b1;
                            end
                        end
                for (int k = 0; k <= dim_z; k++)
                    for (int j = 0; j <= dim_y; j++)
                        for (int i = 0; i <= dim_x; i++) begin
                            n = i + CDIM * (j + CDIM * k);
                            if (corner_grid[n] != 0 &&
                                    in_sphere(i * 256, j * 256, k * 256, cx, cy, cz, r)) begin
                                corner_grid[n] = 0;
                                res.changed = 1'b1;
                            end
                        end
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on result beat %0d: %s got %0d expected %0d",
                 beat_no, what, got, want);
        o_fail_count++;
    endtask

    assign o_pending = expected_results.size();

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        t_vox_result want;
        if (!i_rst_n) begin
            dim_x = DIM;
            dim_y = DIM;
            dim_z = DIM;
            fill_type = 4'd1;
            refill_grids();
            expected_results.delete();
            beat_no = 0;
        end else begin
            // result beat against the oldest prediction
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("result beat %0d arrived with nothing outstanding", beat_no);
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_block_type !== want.btype)
                        report_mismatch("block_type", i_block_type, want.btype);
                    if (i_density !== want.dens)
                        report_mismatch("density", i_density, $signed(want.dens));
                    if (i_ok !== want.ok) report_mismatch("ok", i_ok, want.ok);
                    if (i_changed !== want.changed)
                        report_mismatch("changed", i_changed, want.changed);
                end
                beat_no++;
            end
            // register writes
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    vgsc_pkg::REG_SIZE_X: begin
                        dim_x = clamp_dim(i_cfg_data); refill_grids();
                    end
                    vgsc_pkg::REG_SIZE_Y: begin
                        dim_y = clamp_dim(i_cfg_data); refill_grids();
                    end
                    vgsc_pkg::REG_SIZE_Z: begin
                        dim_z = clamp_dim(i_cfg_data); refill_grids();
                    end
                    default: fill_type = i_cfg_data[3:0];
                endcase
            end
            // command beat
            if (i_valid && i_in_ready)
                expected_results.push_back(apply_command(i_mode, i_coord_x, i_coord_y,
                    i_coord_z, i_new_type, i_center_x, i_center_y, i_center_z,
                    i_radius));
        end
    end

endmodule

@@ bench/voxel_grid_edit_and_sphere_carve_top_test.sv @@
// stimulus and verdict for the voxel grid edit and sphere carve block
`timescale 1ns / 1ps

module voxel_grid_edit_and_sphere_carve_top_test;

    localparam longint CYCLE_LIMIT = 3000000;
    localparam int     N_PHASES    = 9;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [1:0]         i_mode;
    logic signed [7:0]  i_coord_x, i_coord_y, i_coord_z;
    logic [3:0]         i_new_type;
    logic signed [15:0] i_center_x, i_center_y, i_center_z;
    logic [13:0]        i_radius;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index;
    logic [4:0]         i_cfg_data;
    logic               o_valid;
    logic               i_ready;
    logic [3:0]         o_block_type;
    logic signed [1:0]  o_density;
    logic               o_ok;
    logic               o_changed;

    int     fail_count;
    int     pending;
    longint cycle_count;
    bit     no_idle;
    bit     hold_req;
    int     dim_x, dim_y, dim_z;

    voxel_grid_edit_and_sphere_carve_top DUT (.*);

    vgsc_checker scoreboard (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_in_ready(o_ready), .i_mode(i_mode),
        .i_coord_x(i_coord_x), .i_coord_y(i_coord_y), .i_coord_z(i_coord_z),
        .i_new_type(i_new_type), .i_center_x(i_center_x), .i_center_y(i_center_y),
        .i_center_z(i_center_z), .i_radius(i_radius),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_out_valid(o_valid), .i_out_ready(i_ready), .i_block_type(o_block_type),
        .i_density(o_density), .i_ok(o_ok), .i_changed(o_changed),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // watchdog
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("voxel_grid_edit_and_sphere_carve_top verification failed");
            $finish;
        end
    end

    // result side: random stall per beat, one long hold-off on request
    initial begin
        int wait_left;
        i_ready = 1'b0;
        wait_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
            end
            if (o_valid && i_ready) wait_left = no_idle ? 0 : $urandom_range(0, 14);
            if (wait_left > 0) begin
                i_ready <= 1'b0;
                wait_left--;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    function automatic int clamp_dim(logic [4:0] v);
        if (v == 0) return 1;
        if (v > 16) return 16;
        return int'(v);
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [4:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            vgsc_pkg::REG_SIZE_X: dim_x = clamp_dim(val);
            vgsc_pkg::REG_SIZE_Y: dim_y = clamp_dim(val);
            vgsc_pkg::REG_SIZE_Z: dim_z = clamp_dim(val);
            default: ;
        endcase
        // a size write starts a refill sweep of both grids
        if (idx != vgsc_pkg::REG_DEFAULT) repeat (5100) @(posedge i_clk);
    endtask

    task automatic send_cmd(logic [1:0] md, int x, int y, int z, logic [3:0] nt,
                            int cx, int cy, int cz, int r);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_mode     <= md;
        i_coord_x  <= 8'(x);
        i_coord_y  <= 8'(y);
        i_coord_z  <= 8'(z);
        i_new_type <= nt;
        i_center_x <= 16'(cx);
        i_center_y <= 16'(cy);
        i_center_z <= 16'(cz);
        i_radius   <= 14'(r);
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    // coordinate mostly near the grid, sometimes anywhere
    function automatic int pick_coord(int lim);
        if ($urandom_range(0, 9) == 0) return $signed(8'($urandom));
        return $urandom_range(0, lim + 2) - 1;
    endfunction

    function automatic int pick_center(int lim);
        if ($urandom_range(0, 7) == 0) return $signed(16'($urandom));
        return $urandom_range(0, lim * 256 + 1024) - 512;
    endfunction

    initial begin
        logic [4:0] size_tab [N_PHASES][3];
        logic [1:0] md;
        int         carves_left, big;
        size_tab = '{'{5'd16, 5'd16, 5'd16}, '{5'd0, 5'd0, 5'd0}, '{5'd31, 5'd1, 5'd2},
                     '{5'd3, 5'd3, 5'd3}, '{5'd2, 5'd4, 5'd1}, '{5'd4, 5'd4, 5'd4},
                     '{5'd1, 5'd16, 5'd1}, '{5'd5, 5'd2, 5'd3}, '{5'd17, 5'd16, 5'd20}};
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_mode = vgsc_pkg::MODE_SET;
        i_coord_x = 0; i_coord_y = 0; i_coord_z = 0;
        i_new_type = 0;
        i_center_x = 0; i_center_y = 0; i_center_z = 0;
        i_radius = 0;
        i_cfg_valid = 1'b0;
        i_cfg_index = vgsc_pkg::REG_SIZE_X;
        i_cfg_data = 0;
        no_idle = 1'b0;
        hold_req = 1'b0;
        dim_x = 16; dim_y = 16; dim_z = 16;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: edges of the full grid, out of range access, extreme carves
        send_cmd(vgsc_pkg::MODE_SET, 0, 0, 0, 4'd15, 0, 0, 0, 0);
        send_cmd(vgsc_pkg::MODE_SET, 15, 15, 15, 4'd0, 0, 0, 0, 0);
        send_cmd(vgsc_pkg::MODE_SET, -1, 0, 0, 4'd7, 0, 0, 0, 0);
        send_cmd(vgsc_pkg::MODE_SET, 16, 3, 3, 4'd7, 0, 0, 0, 0);
        send_cmd(vgsc_pkg::MODE_SET, 3, 3, 127, 4'd9, 0, 0, 0, 0);
        send_cmd(vgsc_pkg::MODE_RDC, 0, 0, 0, 0, 0, 0, 0, 0);
        send_cmd(vgsc_pkg::MODE_RDC, 15, 15, 15, 0, 0, 0, 0, 0);
        send_cmd(vgsc_pkg::MODE_RDC, -128, 127, 0, 0, 0, 0, 0, 0);
        send_cmd(vgsc_pkg::MODE_RDS, 1, 1, 1, 0, 0, 0, 0, 0);
        send_cmd(vgsc_pkg::MODE_RDS, 16, 16, 16, 0, 0, 0, 0, 0);
        send_cmd(vgsc_pkg::MODE_RDS, 17, 0, 0, 0, 0, 0, 0, 0);
        send_cmd(vgsc_pkg::MODE_RDS, 2, 2, 2, 0, 0, 0, 0, 0);
        send_cmd(vgsc_pkg::MODE_CARVE, 0, 0, 0, 0, 8 * 256, 8 * 256, 8 * 256, 2 * 256);
        send_cmd(vgsc_pkg::MODE_CARVE, 0, 0, 0, 0, 0, 0, 0, 0);
        send_cmd(vgsc_pkg::MODE_CARVE, 0, 0, 0, 0, 8 * 256, 8 * 256, 8 * 256, 2 * 256);
        send_cmd(vgsc_pkg::MODE_RDC, 8, 8, 8, 0, 0, 0, 0, 0);
        send_cmd(vgsc_pkg::MODE_RDS, 0, 0, 0, 0, 0, 0, 0, 0);
        send_cmd(vgsc_pkg::MODE_CARVE, 0, 0, 0, 0, -32768, -32768, -32768, 16383);
        send_cmd(vgsc_pkg::MODE_CARVE, 0, 0, 0, 0, 32767, 32767, 32767, 0);
        send_cmd(vgsc_pkg::MODE_RDS, 8, 8, 8, 0, 0, 0, 0, 0);
        drain();

        for (int p = 1; p < N_PHASES; p++) begin
            // default type goes first so the size writes fill with it
            write_reg(vgsc_pkg::REG_DEFAULT,
                      (p == 1) ? 5'd0 : (p == 2) ? 5'd31 : 5'($urandom));
            write_reg(vgsc_pkg::REG_SIZE_X, size_tab[p][0]);
            write_reg(vgsc_pkg::REG_SIZE_Y, size_tab[p][1]);
            write_reg(vgsc_pkg::REG_SIZE_Z, size_tab[p][2]);
            big = (dim_x * dim_y * dim_z > 100);
            carves_left = big ? 2 : 40;
            no_idle = (p == 4);
            for (int n = 0; n < 66; n++) begin
                if (p == 3 && n == 10) hold_req = 1'b1;
                md = 2'($urandom_range(0, 3));
                if (md == vgsc_pkg::MODE_CARVE) begin
                    if (carves_left == 0) md = vgsc_pkg::MODE_RDC;
                    else carves_left--;
                end
                send_cmd(md, pick_coord(dim_x), pick_coord(dim_y), pick_coord(dim_z),
                         4'($urandom),
                         pick_center(dim_x), pick_center(dim_y), pick_center(dim_z),
                         ($urandom_range(0, 7) == 0) ? 14'($urandom)
                                                     : $urandom_range(0, 3 * 256));
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("voxel_grid_edit_and_sphere_carve_top verification clean");
        end else begin
            $display("voxel_grid_edit_and_sphere_carve_top verification failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/vgsc_pkg.sv
design/vgsc_front.sv
design/vgsc_back.sv
design/voxel_grid_edit_and_sphere_carve_top.sv
bench/vgsc_checker.sv
bench/voxel_grid_edit_and_sphere_carve_top_test.sv
